// ===== rtl/mspid_pkg.sv =====
// ----------------------------------------------------------------------------
// mspid_pkg
// Shared widths and constants of the motor speed PID unit.
// ----------------------------------------------------------------------------
package mspid_pkg;
	localparam int DIV_W = 35;   // serial divider dividend / quotient width
	localparam int DVS_W = 10;   // divisor width
	localparam int ERR_W = 26;   // Q.8 error width
	localparam int ACC_W = 64;   // product accumulator width
	localparam int SUM_W = 48;   // integral width
	localparam logic [DVS_W-1:0] PERIOD_MAX = 10'd1000;
endpackage

// ===== rtl/mspid_div.sv =====
// ----------------------------------------------------------------------------
// mspid_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module mspid_div
	import mspid_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quot
);
	localparam int CNT_W = $clog2(DIV_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] dq_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   rem_sh;
	logic             ge;

	assign rem_sh = {rem_q, dq_q[DIV_W-1]};
	assign ge     = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= DVS_W'(rem_sh - {1'b0, dvs_q});
			end else begin
				rem_q <= rem_sh[DVS_W-1:0];
			end
			dq_q <= {dq_q[DIV_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = dq_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy_q)) else $error("divider done without work");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && cnt_q != CNT_W'(1) |-> !start) else $error("divider restarted");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0) else $error("divider count underflow");
endmodule

// ===== rtl/motor_speed_pid_unit.sv =====
// ----------------------------------------------------------------------------
// motor_speed_pid_unit
// Discrete PID speed controller for one motor, signed Q.8 fixed point.
// ----------------------------------------------------------------------------
// A sample request runs two 35-bit bit-serial divides and five 16-bit
// shift-add multiplies on one shared accumulator; a clear request resets
// the integral and last error and goes straight to the final step.
// Throughput: one request at a time; the next is taken the cycle after the
// result is in the output register. Reset clears gains, target, integral, last error.
module motor_speed_pid_unit
	import mspid_pkg::*;
#(
	parameter int PULSES_PER_REV = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] pulses
	input  logic [0:0]  s_tuser,   // [0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] drive
	output logic [0:0]  m_tuser,   // [0] saturated
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [17:0] cfg_data
);
	localparam logic [2:0] REG_GAIN_P = 3'd0;
	localparam logic [2:0] REG_GAIN_I = 3'd1;
	localparam logic [2:0] REG_GAIN_D = 3'd2;
	localparam logic [2:0] REG_PERIOD = 3'd3;
	localparam logic [2:0] REG_TARGET = 3'd4;

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_MAG_MUL = 4'd1;
	localparam logic [3:0] ST_MAG_DIV = 4'd2;
	localparam logic [3:0] ST_ERR     = 4'd3;
	localparam logic [3:0] ST_INT_MUL = 4'd4;
	localparam logic [3:0] ST_INT_UPD = 4'd5;
	localparam logic [3:0] ST_DER_DIV = 4'd6;
	localparam logic [3:0] ST_GAIN_P  = 4'd7;
	localparam logic [3:0] ST_GAIN_I  = 4'd8;
	localparam logic [3:0] ST_GAIN_D  = 4'd9;
	localparam logic [3:0] ST_FIN     = 4'd10;

	localparam logic signed [17:0] LIMIT = 18'(2 * PULSES_PER_REV);

	logic [15:0]             gain_p_q, gain_i_q, gain_d_q;
	logic [DVS_W-1:0]        period_q;
	logic signed [17:0]      target_q;

	logic [3:0]              st_q;
	logic [15:0]             pulse_q;
	logic signed [ERR_W-1:0] err_q, last_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                    sat_q, dneg_q;
	logic signed [ACC_W-1:0] acc_q, mcand_q, acc_nx;
	logic [15:0]             mbits_q;
	logic [3:0]              mcnt_q;
	logic                    mul_last;
	logic                    fin_go;

	logic                    m_valid_q;
	logic [31:0]             m_drive_q;
	logic                    m_sat_q;

	logic signed [17:0]      tgt_cl;
	logic [16:0]             tmag;
	logic                    tneg, tzero;
	logic [DVS_W-1:0]        period_eff;
	logic signed [26:0]      e27, err27, diff27;
	logic [26:0]             dmag;
	logic signed [35:0]      ep;
	logic signed [SUM_W:0]   s49;
	logic signed [27:0]      deriv;
	logic                    drv_ovf;
	logic [31:0]             drive_v;

	logic                    div_start, div_done;
	logic [DIV_W-1:0]        div_dividend, div_quot;
	logic [DVS_W-1:0]        div_divisor;

	assign cfg_ready = 1'b1;
	assign s_tready  = (st_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= '0;
			gain_i_q <= '0;
			gain_d_q <= '0;
			period_q <= 10'd10;
			target_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_GAIN_P: gain_p_q <= cfg_data[15:0];
				REG_GAIN_I: gain_i_q <= cfg_data[15:0];
				REG_GAIN_D: gain_d_q <= cfg_data[15:0];
				REG_PERIOD: period_q <= cfg_data[DVS_W-1:0];
				REG_TARGET: target_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (target_q > LIMIT) begin
			tgt_cl = LIMIT;
		end else if (target_q < -LIMIT) begin
			tgt_cl = -LIMIT;
		end else begin
			tgt_cl = target_q;
		end
		tneg  = tgt_cl[17];
		tzero = (tgt_cl == '0);
		tmag  = tneg ? 17'(-tgt_cl) : 17'(tgt_cl);
		if (period_q == '0) begin
			period_eff = DVS_W'(1);
		end else if (period_q > PERIOD_MAX) begin
			period_eff = PERIOD_MAX;
		end else begin
			period_eff = period_q;
		end
	end

	assign acc_nx   = acc_q + (mbits_q[0] ? mcand_q : '0);
	assign mul_last = (mcnt_q == 4'd15);
	assign fin_go   = (st_q == ST_FIN) && (!m_valid_q || m_tready);

	// error, derivative, integral sum and drive saturation helpers
	always_comb begin
		e27    = $signed({1'b0, div_quot[ERR_W-1:0]}) - $signed({3'b000, pulse_q, 8'h00});
		err27  = tzero ? '0 : (tneg ? -e27 : e27);
		diff27 = 27'(err_q) - 27'(last_q);
		dmag   = diff27[26] ? 27'(-diff27) : 27'(diff27);
		ep     = acc_q[35:0];
		s49    = (SUM_W+1)'(sum_q) + (SUM_W+1)'(ep);
		deriv  = dneg_q ? -$signed({1'b0, div_quot[26:0]}) : $signed({1'b0, div_quot[26:0]});
		drv_ovf = !((&acc_q[ACC_W-1:39]) || !(|acc_q[ACC_W-1:39]));
		if (drv_ovf) begin
			drive_v = acc_q[ACC_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
		end else begin
			drive_v = acc_q[39:8];
		end
	end

	assign div_start    = (st_q == ST_MAG_MUL && mul_last) || (st_q == ST_INT_UPD);
	assign div_dividend = (st_q == ST_INT_UPD) ? DIV_W'(dmag) : {acc_nx[26:0], 8'h00};
	assign div_divisor  = (st_q == ST_INT_UPD) ? period_eff : PERIOD_MAX;

	mspid_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			sum_q     <= '0;
			last_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						if (s_tuser[0]) begin
							sum_q  <= '0;
							last_q <= '0;
							st_q   <= ST_FIN;
						end else begin
							st_q <= ST_MAG_MUL;
						end
					end
				end
				ST_MAG_MUL: if (mul_last) st_q <= ST_MAG_DIV;
				ST_MAG_DIV: if (div_done) st_q <= ST_ERR;
				ST_ERR:     st_q <= ST_INT_MUL;
				ST_INT_MUL: if (mul_last) st_q <= ST_INT_UPD;
				ST_INT_UPD: begin
					if (s49[SUM_W] != s49[SUM_W-1]) begin
						sum_q <= s49[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
						                    : {1'b0, {(SUM_W-1){1'b1}}};
					end else begin
						sum_q <= s49[SUM_W-1:0];
					end
					last_q <= err_q;
					st_q   <= ST_DER_DIV;
				end
				ST_DER_DIV: if (div_done) st_q <= ST_GAIN_P;
				ST_GAIN_P:  if (mul_last) st_q <= ST_GAIN_I;
				ST_GAIN_I:  if (mul_last) st_q <= ST_GAIN_D;
				ST_GAIN_D:  if (mul_last) st_q <= ST_FIN;
				ST_FIN:     if (fin_go) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// datapath: shared shift-add multiplier and working registers
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				pulse_q <= s_tdata;
				sat_q   <= 1'b0;
				acc_q   <= '0;
				mcand_q <= ACC_W'(tmag);
				mbits_q <= 16'(period_eff);
				mcnt_q  <= '0;
			end
			ST_ERR: begin
				err_q   <= err27[ERR_W-1:0];
				acc_q   <= '0;
				mcand_q <= ACC_W'(err27);
				mbits_q <= 16'(period_eff);
				mcnt_q  <= '0;
			end
			ST_INT_UPD: begin
				dneg_q <= diff27[26];
				if (s49[SUM_W] != s49[SUM_W-1]) sat_q <= 1'b1;
			end
			ST_DER_DIV: begin
				acc_q   <= '0;
				mcand_q <= ACC_W'(err_q);
				mbits_q <= gain_p_q;
				mcnt_q  <= '0;
			end
			ST_MAG_MUL, ST_INT_MUL, ST_GAIN_P, ST_GAIN_I, ST_GAIN_D: begin
				acc_q  <= acc_nx;
				mcnt_q <= mcnt_q + 1'b1;
				if (mul_last && st_q == ST_GAIN_P) begin
					mcand_q <= ACC_W'(sum_q);
					mbits_q <= gain_i_q;
				end else if (mul_last && st_q == ST_GAIN_I) begin
					mcand_q <= ACC_W'(deriv);
					mbits_q <= gain_d_q;
				end else begin
					mcand_q <= mcand_q <<< 1;
					mbits_q <= mbits_q >> 1;
				end
			end
			ST_FIN: begin
				if (fin_go) begin
					m_drive_q <= drive_v;
					m_sat_q   <= sat_q | drv_ovf;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = m_drive_q;
	assign m_tuser[0] = m_sat_q;

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (st_q == ST_MAG_DIV || st_q == ST_DER_DIV))
		else $error("divider result outside a divide step");
	a_clear_state: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[0] |=> sum_q == '0 && last_q == '0)
		else $error("clear request left state");
	a_fin_from: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(st_q) == ST_FIN)
		else $error("result not from final step");
endmodule
